// ===== hw/rtl/swmt_pkg.sv =====
// Shared types and constants for the sliding window median block.
package swmt_pkg;

  localparam int unsigned TIME_W = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

endpackage

// ===== hw/rtl/sliding_window_median_time.sv =====
// Running median of block timestamps over a sliding window, MSB-first radix select.
//
// Input channel (in_valid/in_ready): one request carries block_time and
// chain_restart. A set chain_restart empties the window before block_time
// is inserted. Output channel (out_valid/out_ready): one median_time per
// request, the element at index count/2 of the ascending-sorted window
// (upper median for an even count), count being 1..WINDOW.
//
// Each request is worked on in order: the new timestamp is written into its
// slot, then every stored entry rotates past the selector one bit at a time
// through all TIME_W bits (one result bit per cycle, from a population count
// over the still-active entries), and then the output register is loaded.
// in_ready is high only while the selector is idle, so a new request is
// taken only once the last one has loaded the output register.
//
// A stalled receiver holds the result in the output register; the next
// request can still be taken and worked on, and waits at its end until the
// output register frees up. Synchronous reset empties the window and drops
// any request in progress and any undelivered result.
module sliding_window_median_time #(
  parameter int unsigned WINDOW = 11
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [swmt_pkg::TIME_W-1:0] block_time,
  input  logic                        chain_restart,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [swmt_pkg::TIME_W-1:0] median_time
);

  import swmt_pkg::*;

  localparam int unsigned CW = $clog2(WINDOW + 1);
  localparam int unsigned SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned BW = $clog2(TIME_W);

  state_t state, state_next;

  logic [TIME_W-1:0] win [WINDOW];
  logic [CW-1:0]     fill_count;
  logic [SW-1:0]     oldest_slot;
  logic [WINDOW-1:0] active;
  logic [CW-1:0]     rank;
  logic [BW-1:0]     bit_cnt;
  logic [TIME_W-1:0] res;

  logic              accept;
  logic [CW-1:0]     fc_base;
  logic [SW-1:0]     os_base;
  logic [CW-1:0]     fill_count_next;
  logic [SW-1:0]     oldest_slot_next;
  logic [SW-1:0]     wr_slot;
  logic [WINDOW-1:0] msbs;
  logic [CW-1:0]     zeros;
  logic              res_bit;
  logic              out_free;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // slot selection for the incoming timestamp
  always_comb begin
    fc_base = chain_restart ? '0 : fill_count;
    os_base = chain_restart ? '0 : oldest_slot;
    if (fc_base < CW'(WINDOW)) begin
      wr_slot          = fc_base[SW-1:0];
      fill_count_next  = fc_base + CW'(1);
      oldest_slot_next = os_base;
    end else begin
      wr_slot          = os_base;
      fill_count_next  = fc_base;
      oldest_slot_next = (os_base == SW'(WINDOW - 1)) ? '0 : os_base + SW'(1);
    end
  end

  // count active entries whose current bit is zero
  always_comb begin
    zeros = '0;
    for (int i = 0; i < WINDOW; i++) begin
      msbs[i] = win[i][TIME_W-1];
      zeros   = zeros + CW'(active[i] && !msbs[i]);
    end
    res_bit = !(rank < zeros);
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (bit_cnt == BW'(TIME_W - 1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count  <= '0;
      oldest_slot <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        fill_count  <= fill_count_next;
        oldest_slot <= oldest_slot_next;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // window entries rotate one bit per step; after TIME_W steps they are back
  always_ff @(posedge clk) begin
    for (int i = 0; i < WINDOW; i++) begin
      if (accept && wr_slot == SW'(i)) begin
        win[i] <= block_time;
      end else if (state == ST_RUN) begin
        win[i] <= {win[i][TIME_W-2:0], win[i][TIME_W-1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < WINDOW; i++) begin
        active[i] <= (CW'(i) < fill_count_next);
      end
      rank    <= fill_count_next >> 1;
      bit_cnt <= '0;
    end else if (state == ST_RUN) begin
      active  <= res_bit ? (active & msbs) : (active & ~msbs);
      if (res_bit) rank <= rank - zeros;
      res     <= {res[TIME_W-2:0], res_bit};
      bit_cnt <= bit_cnt + BW'(1);
    end
    if (state == ST_DONE && out_free) begin
      median_time <= res;
    end
  end

endmodule

// ===== sim/sliding_window_median_time_tb.sv =====
// Testbench for sliding_window_median_time: directed, back-pressure and random chain traffic.
module sliding_window_median_time_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swmt_pkg::*;

  localparam int WINDOW        = 11;
  localparam int REQ_CYCLES    = TIME_W + 2;
  localparam int QUIET_LIMIT   = 5000;
  localparam int LONG_HOLD     = 400;

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              in_valid      = 1'b0;
  logic              in_ready;
  logic [TIME_W-1:0] block_time    = '0;
  logic              chain_restart = 1'b0;
  logic              out_valid;
  logic              out_ready     = 1'b0;
  logic [TIME_W-1:0] median_time;

  sliding_window_median_time #(
    .WINDOW(WINDOW)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .block_time   (block_time),
    .chain_restart(chain_restart),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .median_time  (median_time)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: the window contents as the block should hold them.
  logic [TIME_W-1:0] window_times [WINDOW];
  int unsigned       window_fill   = 0;
  int unsigned       window_oldest = 0;
  logic [TIME_W-1:0] expected_medians [$];
  logic [TIME_W-1:0] chain_clock = '0;
  logic [TIME_W-1:0] want_median;
  int                failures      = 0;
  int                tx_idle_pct   = 0;
  int                rx_stall_pct  = 0;
  int                hold_requests = 0;
  int                hold_served   = 0;
  int                hold_left     = 0;
  int                quiet_cycles  = 0;

  function automatic logic [TIME_W-1:0] insert_and_median(input logic [TIME_W-1:0] stamp,
                                                          input logic restart);
    logic [TIME_W-1:0] sorted [WINDOW];
    logic [TIME_W-1:0] v;
    int                j;
    if (restart) begin
      window_fill   = 0;
      window_oldest = 0;
    end
    if (window_fill < WINDOW) begin
      window_times[window_fill] = stamp;
      window_fill++;
    end else begin
      window_times[window_oldest] = stamp;
      window_oldest = (window_oldest + 1) % WINDOW;
    end
    for (int i = 0; i < window_fill; i++) begin
      v = window_times[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    return sorted[window_fill / 2];
  endfunction

  // Mostly plausible chain timestamps (can step backwards), plus noise, duplicates, extremes.
  function automatic logic [TIME_W-1:0] next_stamp();
    logic [TIME_W-1:0] stamp;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        chain_clock = chain_clock + $urandom_range(0, 1500) - 400;
        stamp = chain_clock;
      end
      5, 6: stamp = $urandom();
      7: stamp = $urandom_range(0, 7);
      8: begin
        case ($urandom_range(0, 3))
          0: stamp = '0;
          1: stamp = '1;
          2: stamp = 32'h0000_0001;
          default: stamp = 32'hFFFF_FFFE;
        endcase
      end
      default: stamp = chain_clock;
    endcase
    return stamp;
  endfunction

  task automatic send_stamp(input logic [TIME_W-1:0] stamp, input logic restart);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    block_time    <= stamp;
    chain_restart <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_medians.push_back(insert_and_median(stamp, restart));
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_medians.size() != 0) @(posedge clk);
  endtask

  // Result checker and receiver ready generation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_medians.size() == 0) begin
        $error("median_time: no request outstanding, got %0d", median_time);
        failures++;
      end else begin
        want_median = expected_medians.pop_front();
        if (median_time !== want_median) begin
          $error("median_time mismatch: expected %0d, got %0d", want_median, median_time);
          failures++;
        end
      end
    end
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("sliding_window_median_time_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Fill from reset without restart, wrap past a full window, duplicates, even counts.
  task automatic test_window_edges();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_stamp(32'hFFFF_FFFF, 1'b0);
    send_stamp(32'h0000_0000, 1'b0);
    send_stamp(32'd5, 1'b0);
    send_stamp(32'd5, 1'b0);
    send_stamp(32'h8000_0000, 1'b0);
    send_stamp(32'd1, 1'b0);
    send_stamp(32'hFFFF_FFFE, 1'b0);
    send_stamp(32'd5, 1'b0);
    send_stamp(32'd7, 1'b0);
    send_stamp(32'd3, 1'b0);
    send_stamp(32'd9, 1'b0);
    send_stamp(32'd2, 1'b0);
    send_stamp(32'hFFFF_FFFF, 1'b0);
    send_stamp(32'h7FFF_FFFF, 1'b0);
    // restart on a full window, then an even count picks the upper median
    send_stamp(32'd100, 1'b1);
    send_stamp(32'd50, 1'b0);
    send_stamp(32'd50, 1'b0);
    send_stamp(32'h0000_0000, 1'b1);
    send_stamp(32'hFFFF_FFFF, 1'b1);
    send_stamp(32'h0000_0000, 1'b0);
    wait_results_drained();
  endtask

  // Receiver holds off while requests keep coming, so the input side stalls.
  task automatic test_output_hold();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_requests++;
    chain_clock = $urandom();
    for (int k = 0; k < 10; k++) begin
      send_stamp(next_stamp(), k == 0);
    end
    wait_results_drained();
  endtask

  task automatic run_random_chains(input int n_items, input int tx_pct, input int rx_pct);
    int   sent;
    int   chain_len;
    logic restart;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      chain_len   = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
      chain_clock = $urandom();
      for (int k = 0; k < chain_len && sent < n_items; k++) begin
        // mostly a restart at chain start; occasional stray restarts mid-chain
        if (k == 0) restart = ($urandom_range(0, 9) != 0);
        else        restart = ($urandom_range(0, 49) == 0);
        send_stamp(next_stamp(), restart);
        sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    run_random_chains(180, 0, 0);
    run_random_chains(180, 83, 0);
    run_random_chains(180, 0, 83);
    run_random_chains(180, 21, 21);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_window_edges();
    test_output_hold();
    test_random_traffic();
    wait_results_drained();
    repeat (3 * REQ_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("sliding_window_median_time_tb passed");
    end else begin
      $display("sliding_window_median_time_tb failed");
    end
    $finish;
  end

endmodule
